### src/sscp_pkg.sv
// sscp_pkg: shared types, character codes and status codes for the serial
// setting command parser. No dependencies.
`default_nettype none

package sscp_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;

    typedef enum logic [1:0] {
        ST_WRITTEN = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_LISTING = 2'd2
    } t_status;

    localparam t_byte CH_NL    = 8'h0A;
    localparam t_byte CH_DOLR  = 8'h24;
    localparam t_byte CH_PLUS  = 8'h2B;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_EQ    = 8'h3D;

    localparam t_word CODE_CAP = 16'd32767;
    localparam t_word VAL_CAP  = 16'd32768;
    localparam t_word POS_MAX  = 16'd32767;

    localparam t_word CODE_LOW_TEMP  = 16'd1;
    localparam t_word CODE_HIGH_TEMP = 16'd2;
    localparam t_word CODE_MIN_LUX   = 16'd3;

    // acc * 10 + d, clamped to cap
    function automatic t_word push_digit(input t_word acc, input logic [3:0] d,
                                         input t_word cap);
        logic [19:0] n;
        n = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
        if (n > {4'd0, cap}) begin
            n = {4'd0, cap};
        end
        return n[15:0];
    endfunction

endpackage

`default_nettype wire

### src/serial_setting_command_parser.sv
// serial_setting_command_parser: parses "$code=value\n" lines one byte per
// cycle and keeps three 16-bit settings. Depends on sscp_pkg.
//
//   channel | signals                                         | direction
//   rx      | i_rx_valid, o_rx_ready, i_rx_byte               | in
//   res     | o_res_valid, i_res_ready, o_status, o_setting_code,
//           | o_echoed_value, o_low_temp_now, o_high_temp_now,
//           | o_min_lux_now                                   | out
//
// One byte per cycle sustained while each result is taken. A byte is first registered
// in the input register; then one pass of parse logic updates the line state and,
// on a newline, loads the result register. Synchronous active-low reset clears
// line state, settings and valids.
// A result not yet taken holds the parse stage for every byte; the input
// register then fills and o_rx_ready drops until the result transfers.
`default_nettype none

module serial_setting_command_parser #(
    parameter int LINE_CHARS = 12
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_rx_valid,
    output logic         o_rx_ready,
    input  wire  [7:0]   i_rx_byte,
    output logic         o_res_valid,
    input  wire          i_res_ready,
    output logic [1:0]   o_status,
    output logic [14:0]  o_setting_code,
    output logic [15:0]  o_echoed_value,
    output logic [15:0]  o_low_temp_now,
    output logic [15:0]  o_high_temp_now,
    output logic [15:0]  o_min_lux_now
);

    localparam int CNT_W = $clog2(LINE_CHARS + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CODE,
        PH_VSTART,
        PH_VALUE
    } t_phase;

    // input register
    logic               r_in_valid;
    sscp_pkg::t_byte    r_in_byte;

    // line state
    t_phase             r_phase,   n_phase;
    logic [CNT_W-1:0]   r_cnt,     n_cnt;
    sscp_pkg::t_word    r_code,    n_code;
    sscp_pkg::t_word    r_val,     n_val;
    logic               r_neg,     n_neg;
    logic               r_closed,  n_closed;
    sscp_pkg::t_word    r_lo,      n_lo;
    sscp_pkg::t_word    r_hi,      n_hi;
    sscp_pkg::t_word    r_lux,     n_lux;

    // result register
    logic               r_res_valid;
    logic               n_emit;
    sscp_pkg::t_status  r_status,  n_status;
    logic [14:0]        r_scode,   n_scode;
    sscp_pkg::t_word    r_echo,    n_echo;
    sscp_pkg::t_word    r_lo_now;
    sscp_pkg::t_word    r_hi_now;
    sscp_pkg::t_word    r_lux_now;

    logic               out_free;
    logic               advance;
    logic               is_digit;
    logic [3:0]         digit;
    sscp_pkg::t_word    v_final;

    assign out_free   = !r_res_valid || i_res_ready;
    assign advance    = r_in_valid && out_free;
    assign o_rx_ready = !r_in_valid || advance;

    assign is_digit = (r_in_byte >= sscp_pkg::CH_ZERO) && (r_in_byte <= sscp_pkg::CH_NINE);
    assign digit    = r_in_byte[3:0];
    assign v_final  = r_neg ? (16'd0 - r_val)
                            : ((r_val > sscp_pkg::POS_MAX) ? sscp_pkg::POS_MAX : r_val);

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_code   = r_code;
        n_val    = r_val;
        n_neg    = r_neg;
        n_closed = r_closed;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_lux    = r_lux;
        n_emit   = 1'b0;
        n_status = sscp_pkg::ST_LISTING;
        n_scode  = '0;
        n_echo   = '0;

        priority if (r_cnt >= CNT_W'(LINE_CHARS)) begin
            // overlong line: drop byte and restart
            n_phase  = PH_IDLE;
            n_cnt    = '0;
            n_code   = '0;
            n_val    = '0;
            n_neg    = 1'b0;
            n_closed = 1'b0;
        end else if (r_in_byte == sscp_pkg::CH_NL) begin
            if (r_phase == PH_CODE) begin
                n_emit   = 1'b1;
                n_status = sscp_pkg::ST_LISTING;
            end else if (r_phase == PH_VSTART || r_phase == PH_VALUE) begin
                n_emit = 1'b1;
                if (r_code == sscp_pkg::CODE_LOW_TEMP) begin
                    n_lo = v_final;
                end
                if (r_code == sscp_pkg::CODE_HIGH_TEMP) begin
                    n_hi = v_final;
                end
                if (r_code == sscp_pkg::CODE_MIN_LUX) begin
                    n_lux = v_final;
                end
                n_scode = r_code[14:0];
                if (r_code >= sscp_pkg::CODE_LOW_TEMP && r_code <= sscp_pkg::CODE_MIN_LUX) begin
                    n_status = sscp_pkg::ST_WRITTEN;
                    n_echo   = v_final;
                end else begin
                    n_status = sscp_pkg::ST_UNKNOWN;
                end
            end
            n_phase  = PH_IDLE;
            n_cnt    = '0;
            n_code   = '0;
            n_val    = '0;
            n_neg    = 1'b0;
            n_closed = 1'b0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (r_cnt == '0 && r_in_byte == sscp_pkg::CH_DOLR) begin
                        n_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (r_in_byte == sscp_pkg::CH_EQ) begin
                        n_phase  = PH_VSTART;
                        n_closed = 1'b0;
                    end else if (is_digit && !r_closed) begin
                        n_code = sscp_pkg::push_digit(r_code, digit, sscp_pkg::CODE_CAP);
                    end else if (!is_digit) begin
                        n_closed = 1'b1;
                    end
                end
                PH_VSTART: begin
                    n_phase = PH_VALUE;
                    if (r_in_byte == sscp_pkg::CH_MINUS) begin
                        n_neg = 1'b1;
                    end else if (is_digit) begin
                        n_val = sscp_pkg::push_digit(r_val, digit, sscp_pkg::VAL_CAP);
                    end else if (r_in_byte != sscp_pkg::CH_PLUS) begin
                        n_closed = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (is_digit && !r_closed) begin
                        n_val = sscp_pkg::push_digit(r_val, digit, sscp_pkg::VAL_CAP);
                    end else if (!is_digit) begin
                        n_closed = 1'b1;
                    end
                end
                default: ;
            endcase
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_code      <= '0;
            r_val       <= '0;
            r_neg       <= 1'b0;
            r_closed    <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_lux       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (advance) begin
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_code      <= n_code;
                r_val       <= n_val;
                r_neg       <= n_neg;
                r_closed    <= n_closed;
                r_lo        <= n_lo;
                r_hi        <= n_hi;
                r_lux       <= n_lux;
                r_res_valid <= n_emit;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && n_emit) begin
            r_status  <= n_status;
            r_scode   <= n_scode;
            r_echo    <= n_echo;
            r_lo_now  <= n_lo;
            r_hi_now  <= n_hi;
            r_lux_now <= n_lux;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_status        = r_status;
    assign o_setting_code  = r_scode;
    assign o_echoed_value  = r_echo;
    assign o_low_temp_now  = r_lo_now;
    assign o_high_temp_now = r_hi_now;
    assign o_min_lux_now   = r_lux_now;

    a_listing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status == sscp_pkg::ST_LISTING)
            |-> (o_setting_code == 15'd0 && o_echoed_value == 16'd0))
        else $error("listing carries nonzero code or value");

    a_written_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status == sscp_pkg::ST_WRITTEN)
            |-> (o_setting_code == 15'd1 || o_setting_code == 15'd2
                 || o_setting_code == 15'd3))
        else $error("write reported for an invalid code");

    a_result_from_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_emit) |-> (r_in_byte == sscp_pkg::CH_NL))
        else $error("result produced by a byte other than newline");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(LINE_CHARS))
        else $error("line character count overran");

endmodule

`default_nettype wire

### dv/tb_serial_setting_command_parser.sv
// Self-checking bench for serial_setting_command_parser: byte stream in, setting reports out.
// Predicts each report from a bench-side line parser; depends on sscp_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_serial_setting_command_parser;

    localparam int LINE_LEN    = 12;
    localparam int HOLD_LEN    = 300;   // long receiver hold-off
    localparam int STALL_LIMIT = 4000;  // cycles with no transfer before giving up
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_BYTES = 400;

    typedef enum logic [1:0] {
        LN_IDLE   = 2'd0,
        LN_CODE   = 2'd1,
        LN_VSTART = 2'd2,
        LN_VALUE  = 2'd3
    } t_line_phase;

    typedef struct {
        sscp_pkg::t_status status;
        logic [14:0]       code;
        sscp_pkg::t_word   echo;
        sscp_pkg::t_word   lo;
        sscp_pkg::t_word   hi;
        sscp_pkg::t_word   lux;
    } t_setting_report;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic [7:0]  rx_byte = 8'd0;
    logic        res_ready = 1'b0;
    wire         rx_ready;
    wire         res_valid;
    wire [1:0]   res_status;
    wire [14:0]  res_code;
    wire [15:0]  res_echo;
    wire [15:0]  res_lo;
    wire [15:0]  res_hi;
    wire [15:0]  res_lux;

    serial_setting_command_parser #(
        .LINE_CHARS(LINE_LEN)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_rx_valid     (rx_valid),
        .o_rx_ready     (rx_ready),
        .i_rx_byte      (rx_byte),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_status       (res_status),
        .o_setting_code (res_code),
        .o_echoed_value (res_echo),
        .o_low_temp_now (res_lo),
        .o_high_temp_now(res_hi),
        .o_min_lux_now  (res_lux)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- line parser prediction ----------------
    t_line_phase     ln_phase = LN_IDLE;
    int              ln_count = 0;
    sscp_pkg::t_word code_sum = '0;
    sscp_pkg::t_word value_mag = '0;
    logic            value_neg = 1'b0;
    logic            number_done = 1'b0;
    sscp_pkg::t_word low_temp = '0;
    sscp_pkg::t_word high_temp = '0;
    sscp_pkg::t_word min_lux = '0;

    t_setting_report expected_reports[$];

    function automatic sscp_pkg::t_word shift_in_digit(input sscp_pkg::t_word acc,
                                                       input logic [3:0] d,
                                                       input sscp_pkg::t_word cap);
        int unsigned n;
        n = 32'(acc) * 10 + 32'(d);
        if (n > 32'(cap)) begin
            n = 32'(cap);
        end
        return sscp_pkg::t_word'(n);
    endfunction

    function automatic void clear_line();
        ln_phase    = LN_IDLE;
        ln_count    = 0;
        code_sum    = '0;
        value_mag   = '0;
        value_neg   = 1'b0;
        number_done = 1'b0;
    endfunction

    function automatic void file_report(input sscp_pkg::t_status st,
                                        input sscp_pkg::t_word code,
                                        input sscp_pkg::t_word echo);
        t_setting_report rpt;
        rpt.status = st;
        rpt.code   = code[14:0];
        rpt.echo   = echo;
        rpt.lo     = low_temp;
        rpt.hi     = high_temp;
        rpt.lux    = min_lux;
        expected_reports.push_back(rpt);
    endfunction

    function automatic void parse_rx_byte(input sscp_pkg::t_byte b);
        logic            is_dig;
        logic [3:0]      dig;
        sscp_pkg::t_word v;
        is_dig = (b >= sscp_pkg::CH_ZERO && b <= sscp_pkg::CH_NINE);
        dig    = is_dig ? 4'(b - sscp_pkg::CH_ZERO) : 4'd0;
        // full line buffer: byte dropped, line thrown away
        if (ln_count >= LINE_LEN) begin
            clear_line();
            return;
        end
        if (b == sscp_pkg::CH_NL) begin
            if (ln_phase == LN_CODE) begin
                file_report(sscp_pkg::ST_LISTING, '0, '0);
            end else if (ln_phase == LN_VSTART || ln_phase == LN_VALUE) begin
                if (value_neg) begin
                    v = 16'd0 - value_mag;
                end else begin
                    v = (value_mag > sscp_pkg::POS_MAX) ? sscp_pkg::POS_MAX : value_mag;
                end
                if (code_sum == sscp_pkg::CODE_LOW_TEMP) begin
                    low_temp = v;
                end else if (code_sum == sscp_pkg::CODE_HIGH_TEMP) begin
                    high_temp = v;
                end else if (code_sum == sscp_pkg::CODE_MIN_LUX) begin
                    min_lux = v;
                end
                if (code_sum >= sscp_pkg::CODE_LOW_TEMP &&
                    code_sum <= sscp_pkg::CODE_MIN_LUX) begin
                    file_report(sscp_pkg::ST_WRITTEN, code_sum, v);
                end else begin
                    file_report(sscp_pkg::ST_UNKNOWN, code_sum, '0);
                end
            end
            clear_line();
            return;
        end
        case (ln_phase)
            LN_IDLE: begin
                if (ln_count == 0 && b == sscp_pkg::CH_DOLR) begin
                    ln_phase = LN_CODE;
                end
            end
            LN_CODE: begin
                if (b == sscp_pkg::CH_EQ) begin
                    ln_phase    = LN_VSTART;
                    number_done = 1'b0;
                end else if (is_dig && !number_done) begin
                    code_sum = shift_in_digit(code_sum, dig, sscp_pkg::CODE_CAP);
                end else if (!is_dig) begin
                    number_done = 1'b1;
                end
            end
            LN_VSTART: begin
                ln_phase = LN_VALUE;
                if (b == sscp_pkg::CH_MINUS) begin
                    value_neg = 1'b1;
                end else if (is_dig) begin
                    value_mag = shift_in_digit(value_mag, dig, sscp_pkg::VAL_CAP);
                end else if (b != sscp_pkg::CH_PLUS) begin
                    number_done = 1'b1;
                end
            end
            default: begin
                if (is_dig && !number_done) begin
                    value_mag = shift_in_digit(value_mag, dig, sscp_pkg::VAL_CAP);
                end else if (!is_dig) begin
                    number_done = 1'b1;
                end
            end
        endcase
        ln_count++;
    endfunction

    // ---------------- stimulus generation ----------------
    sscp_pkg::t_byte byte_q[$];
    int    bytes_queued = 0;
    int    idle_pct = 0;
    int    stall_pct = 0;
    logic  hold_armed = 1'b0;
    int    hold_count = 0;
    int    mismatches = 0;
    int    quiet_cycles = 0;

    function automatic void queue_byte(input sscp_pkg::t_byte b);
        byte_q.push_back(b);
        bytes_queued++;
    endfunction

    function automatic sscp_pkg::t_byte digit_char();
        return sscp_pkg::CH_ZERO + sscp_pkg::t_byte'($urandom_range(9));
    endfunction

    function automatic sscp_pkg::t_byte code_char();
        return sscp_pkg::CH_ZERO + sscp_pkg::t_byte'($urandom_range(1, 3));
    endfunction

    function automatic void queue_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++) begin
            queue_byte(sscp_pkg::t_byte'(s[k]));
        end
        queue_byte(sscp_pkg::CH_NL);
    endfunction

    function automatic void queue_random_line();
        int kind;
        int r;
        kind = $urandom_range(99);
        if (kind < 72) begin
            // command line with random content
            queue_byte(sscp_pkg::CH_DOLR);
            r = $urandom_range(9);
            if (r <= 5) begin
                queue_byte(code_char());
            end else if (r == 6) begin
                repeat ($urandom_range(1, 5)) queue_byte(digit_char());
            end else if (r == 7) begin
                // sign or junk ends the code early
                queue_byte($urandom_range(1) ? sscp_pkg::CH_MINUS : sscp_pkg::CH_PLUS);
                queue_byte(digit_char());
            end else if (r == 8) begin
                queue_byte(digit_char());
                queue_byte(sscp_pkg::t_byte'($urandom_range(8'h3A, 8'h7E)));
                queue_byte(digit_char());
            end
            if ($urandom_range(9) != 0) begin
                queue_byte(sscp_pkg::CH_EQ);
                r = $urandom_range(5);
                if (r == 0) begin
                    queue_byte(sscp_pkg::CH_MINUS);
                end else if (r == 1) begin
                    queue_byte(sscp_pkg::CH_PLUS);
                end else if (r == 2) begin
                    queue_byte(sscp_pkg::t_byte'($urandom_range(8'h3A, 8'h7E)));
                end
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(11) == 0) begin
                        queue_byte(sscp_pkg::t_byte'($urandom_range(8'h20, 8'h2F)));
                    end else begin
                        queue_byte(digit_char());
                    end
                end
            end
            queue_byte(sscp_pkg::CH_NL);
        end else if (kind < 82) begin
            repeat ($urandom_range(1, 15)) queue_byte(sscp_pkg::t_byte'($urandom_range(255)));
            if ($urandom_range(1)) begin
                queue_byte(sscp_pkg::CH_NL);
            end
        end else if (kind < 90) begin
            // '$' not in first position must be ignored
            queue_byte(sscp_pkg::t_byte'($urandom_range(8'h21, 8'h7E)));
            queue_byte(sscp_pkg::CH_DOLR);
            queue_byte(code_char());
            queue_byte(sscp_pkg::CH_EQ);
            queue_byte(digit_char());
            queue_byte(sscp_pkg::CH_NL);
        end else begin
            // around the buffer limit: 8 digits fit, 9 or more overflow
            queue_byte(sscp_pkg::CH_DOLR);
            queue_byte(code_char());
            queue_byte(sscp_pkg::CH_EQ);
            repeat ($urandom_range(8, 12)) queue_byte(digit_char());
            queue_byte(sscp_pkg::CH_NL);
        end
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else begin
            if (rx_valid && rx_ready) begin
                parse_rx_byte(rx_byte);
            end
            if (!rx_valid || rx_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    rx_valid <= 1'b1;
                    rx_byte  <= byte_q.pop_front();
                end else begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ready ----------------
    always @(posedge clk) begin
        if (hold_armed && hold_count < HOLD_LEN) begin
            res_ready  <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin : mon
        t_setting_report want;
        if (rst_n && res_valid && res_ready) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected report: status=%0d code=%0d value=%0d",
                             res_status, res_code, $signed(res_echo));
                end
            end else begin
                want = expected_reports.pop_front();
                if (res_status !== want.status || res_code !== want.code ||
                    res_echo !== want.echo || res_lo !== want.lo ||
                    res_hi !== want.hi || res_lux !== want.lux) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp st=%0d code=%0d val=%0d lo=%0d hi=%0d lux=%0d",
                                 want.status, want.code, $signed(want.echo),
                                 $signed(want.lo), $signed(want.hi), $signed(want.lux));
                        $display("          got st=%0d code=%0d val=%0d lo=%0d hi=%0d lux=%0d",
                                 res_status, res_code, $signed(res_echo),
                                 $signed(res_lo), $signed(res_hi), $signed(res_lux));
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk) begin
        if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- test sequence ----------------
    initial begin
        int p;
        int target;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturation both ways, sign handling, listing, unknown code,
        // ignored line, empty value, high byte
        queue_text("$1=-40000");
        queue_text("$2=+7");
        queue_text("$3=40000");
        queue_text("$9=5");
        queue_text("$");
        queue_text("x$1=3");
        queue_text("$2=-");
        queue_byte(8'hFF);
        queue_byte(sscp_pkg::CH_NL);
        while (byte_q.size() != 0) @(negedge clk);

        for (p = 0; p < 4; p++) begin
            @(negedge clk);
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 83; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target) queue_random_line();
            while (byte_q.size() != 0) @(negedge clk);
        end

        // back-pressure: receiver holds off while the sender keeps streaming commands
        @(negedge clk);
        idle_pct   = 0;
        stall_pct  = 0;
        hold_armed = 1'b1;
        repeat (40) begin
            queue_byte(sscp_pkg::CH_DOLR);
            queue_byte(code_char());
            queue_byte(sscp_pkg::CH_EQ);
            repeat ($urandom_range(1, 4)) queue_byte(digit_char());
            queue_byte(sscp_pkg::CH_NL);
        end

        while (byte_q.size() != 0 || rx_valid || expected_reports.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
src/sscp_pkg.sv
src/serial_setting_command_parser.sv
dv/tb_serial_setting_command_parser.sv
